// ===== sv/http_header_name_classifier_core_assert.svh =====
// assertion macros for the classifier rtl
`ifndef HTTP_HEADER_NAME_CLASSIFIER_CORE_ASSERT_SVH
`define HTTP_HEADER_NAME_CLASSIFIER_CORE_ASSERT_SVH

// checked on every rising edge outside reset
`define HHNC_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every rising edge, reset included
`define HHNC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== sv/hhnc_pkg.sv =====
// types, constants and the keyword dictionary of the header name classifier
package hhnc_pkg;

  localparam int unsigned NUM_KEYWORDS    = 49;
  localparam int unsigned MAX_KEYWORD_LEN = 19;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned INDEX_W         = 6;
  localparam int unsigned POS_W           = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int unsigned POS_IDX_W       = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
  localparam int unsigned KW_BITS         = CHAR_W * MAX_KEYWORD_LEN;

  localparam logic [NUM_KEYWORDS-1:0] ALL_ALIVE = {NUM_KEYWORDS{1'b1}};

  // dictionary, already case folded; each string sits right-justified
  localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    "connection", "date", "authorization", "if-modified-since", "server",
    "www-authenticate", "expires", "last-modified",
    "cache-control", "pragma", "trailer", "transfer-encoding", "upgrade",
    "via", "warning",
    "accept", "accept-charset", "accept-encoding", "accept-language",
    "expect", "from", "host", "if-match", "if-none-match", "if-range",
    "if-unmodified-since", "max-forwards", "proxy-authorization", "range",
    "referer", "te", "user-agent",
    "accept-ranges", "age", "etag", "location", "proxy-authenticate",
    "retry-after", "vary",
    "allow", "content-encoding", "content-language", "content-length",
    "content-location", "content-md5", "content-range", "content-type",
    "x-sessioncookie", "x-server-ip-address"
  };

  // one input word: a token byte with its flags
  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
    logic              empty_token;
  } hhnc_word_t;

  // lookup outcome for the word in the input register
  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] header_index;
    logic               found;
  } hhnc_res_t;

  // keyword length: count of non-zero bytes from the bottom
  function automatic int unsigned kw_len(logic [KW_BITS-1:0] text);
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < MAX_KEYWORD_LEN; i++) begin
      if (text[i*CHAR_W +: CHAR_W] != '0) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  // ascii upper case letters to lower case, everything else untouched
  function automatic logic [CHAR_W-1:0] fold_case(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== sv/hhnc_if.sv =====
// valid/ready channel interfaces for token bytes and lookup results
interface hhnc_in_if;
  logic                          valid;
  logic                          ready;
  logic [hhnc_pkg::CHAR_W-1:0]   text_char;
  logic                          last_char;
  logic                          empty_token;

  modport source (output valid, output text_char, output last_char,
                  output empty_token, input ready);
  modport sink   (input valid, input text_char, input last_char,
                  input empty_token, output ready);
endinterface

interface hhnc_out_if;
  logic                          valid;
  logic                          ready;
  logic [hhnc_pkg::INDEX_W-1:0]  header_index;
  logic                          found;

  modport source (output valid, output header_index, output found, input ready);
  modport sink   (input valid, input header_index, input found, output ready);
endinterface

// ===== sv/hhnc_match.sv =====
// per-keyword alive bits, character position and final-byte lookup
`include "http_header_name_classifier_core_assert.svh"

module hhnc_match (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hhnc_pkg::hhnc_word_t word_i,
  input  logic                 step_i,
  output hhnc_pkg::hhnc_res_t  res_o
);

  logic [hhnc_pkg::NUM_KEYWORDS-1:0]  alive_q, alive_d;
  logic [hhnc_pkg::NUM_KEYWORDS-1:0]  keep;
  logic [hhnc_pkg::NUM_KEYWORDS-1:0]  hit;
  logic [hhnc_pkg::POS_W-1:0]         pos_q, pos_d;
  logic [hhnc_pkg::POS_W-1:0]         pos_next;
  logic [hhnc_pkg::POS_IDX_W-1:0]     pos_idx;
  logic                               pos_in_range;
  logic [hhnc_pkg::CHAR_W-1:0]        char_fold;
  logic [hhnc_pkg::INDEX_W-1:0]       hit_index;
  logic                               hit_any;

  // folded byte and saturating position
  assign char_fold    = hhnc_pkg::fold_case(word_i.text_char);
  assign pos_in_range = pos_q < hhnc_pkg::POS_W'(hhnc_pkg::MAX_KEYWORD_LEN);
  assign pos_idx      = pos_q[hhnc_pkg::POS_IDX_W-1:0];
  assign pos_next     = pos_in_range ? pos_q + 1'b1
                                     : hhnc_pkg::POS_W'(hhnc_pkg::MAX_KEYWORD_LEN);

  // one comparator per keyword against its character at the current position
  for (genvar k = 0; k < hhnc_pkg::NUM_KEYWORDS; k++) begin : g_kw
    localparam int unsigned Len = hhnc_pkg::kw_len(hhnc_pkg::KW_TEXT[k]);
    logic [hhnc_pkg::CHAR_W-1:0] row [hhnc_pkg::MAX_KEYWORD_LEN];

    for (genvar i = 0; i < hhnc_pkg::MAX_KEYWORD_LEN; i++) begin : g_ch
      if (i < Len) begin : g_used
        assign row[i] = hhnc_pkg::KW_TEXT[k][(Len-1-i)*hhnc_pkg::CHAR_W +: hhnc_pkg::CHAR_W];
      end else begin : g_pad
        assign row[i] = '0;
      end
    end

    assign keep[k] = alive_q[k] && pos_in_range && (pos_q < hhnc_pkg::POS_W'(Len))
                     && (row[pos_idx] == char_fold);
    assign hit[k]  = keep[k] && (pos_next == hhnc_pkg::POS_W'(Len));
  end

  // lowest surviving keyword of matching length wins
  always_comb begin
    hit_index = '0;
    hit_any   = 1'b0;
    for (int k = hhnc_pkg::NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        hit_index = hhnc_pkg::INDEX_W'(k);
        hit_any   = 1'b1;
      end
    end
  end

  // result for a final byte or an empty token
  always_comb begin
    res_o.valid        = word_i.last_char || word_i.empty_token;
    res_o.found        = hit_any && !word_i.empty_token;
    res_o.header_index = word_i.empty_token ? '0 : hit_index;
  end

  // state update, back to start values once a token ends
  always_comb begin
    alive_d = alive_q;
    pos_d   = pos_q;
    if (step_i) begin
      if (res_o.valid) begin
        alive_d = hhnc_pkg::ALL_ALIVE;
        pos_d   = '0;
      end else begin
        alive_d = keep;
        pos_d   = pos_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= hhnc_pkg::ALL_ALIVE;
      pos_q   <= '0;
    end else begin
      alive_q <= alive_d;
      pos_q   <= pos_d;
    end
  end

  `HHNC_ASSERT_ALWAYS(a_pos_saturates, clk_i, !rst_ni || (pos_q <= hhnc_pkg::POS_W'(hhnc_pkg::MAX_KEYWORD_LEN)), "character position beyond saturation")
  `HHNC_ASSERT(a_token_restart, clk_i, rst_ni, step_i && res_o.valid |=> (alive_q == hhnc_pkg::ALL_ALIVE) && (pos_q == '0), "state not restarted after token end")
  `HHNC_ASSERT(a_alive_shrinks, clk_i, rst_ni, step_i && !res_o.valid |=> (alive_q & ~$past(alive_q)) == '0, "alive bit revived inside a token")
  `HHNC_ASSERT(a_single_hit, clk_i, rst_ni, res_o.valid && res_o.found |-> $onehot(hit), "more than one keyword matched")

endmodule

// ===== sv/hhnc_out_stage.sv =====
// result register towards the output channel
module hhnc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hhnc_pkg::hhnc_res_t res_i,
  input  logic                load_i,
  output logic                free_o,
  hhnc_out_if.source          out_o
);

  logic                         valid_q, valid_d;
  logic [hhnc_pkg::INDEX_W-1:0] index_q;
  logic                         found_q;

  // room for a new word when empty or being drained
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      index_q <= res_i.header_index;
      found_q <= res_i.found;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.header_index = index_q;
  assign out_o.found        = found_q;

endmodule

// ===== sv/http_header_name_classifier_core.sv =====
// top level: input register, keyword matcher and result register
// a result word is loaded into the result register as its final byte leaves the input register
// throughput: one byte per cycle while the result register is free, no bubbles between tokens
// a byte can enter while a finished result still waits in the output register
// reset: output empty, all keywords alive, character position zero
module http_header_name_classifier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  hhnc_in_if.sink     in_i,
  hhnc_out_if.source  out_o
);

  logic                 in_valid_q, in_valid_d;
  hhnc_pkg::hhnc_word_t in_word_q;
  logic                 accept;
  logic                 step;
  logic                 out_free;
  hhnc_pkg::hhnc_res_t  res;

  // input register handshake
  assign step       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || step;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q.text_char   <= in_i.text_char;
      in_word_q.last_char   <= in_i.last_char;
      in_word_q.empty_token <= in_i.empty_token;
    end
  end

  // keyword matching
  hhnc_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (in_word_q),
    .step_i (step),
    .res_o  (res)
  );

  // result register
  hhnc_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .load_i (step && res.valid),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule

// ===== bench/http_header_name_classifier_core_tb.sv =====
// self-checking bench for the http header name classifier core
module http_header_name_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef byte unsigned token_t[$];

  // one pending input word, optionally held back until all lookups are out
  typedef struct {
    hhnc_pkg::hhnc_word_t word;
    bit                   drain_first;
  } pending_word_t;

  // outcome of one finished token
  typedef struct packed {
    logic [hhnc_pkg::INDEX_W-1:0] header_index;
    logic                         found;
  } lookup_t;

  localparam int RANDOM_WORDS = 500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hhnc_in_if  in_if ();
  hhnc_out_if out_if ();

  http_header_name_classifier_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // header names in their usual spelling, table order
  string header_names [hhnc_pkg::NUM_KEYWORDS] = '{
    "Connection", "Date", "Authorization", "If-Modified-Since", "Server",
    "WWW-Authenticate", "Expires", "Last-Modified",
    "Cache-Control", "Pragma", "Trailer", "Transfer-Encoding", "Upgrade",
    "Via", "Warning",
    "Accept", "Accept-Charset", "Accept-Encoding", "Accept-Language",
    "Expect", "From", "Host", "If-Match", "If-None-Match", "If-Range",
    "If-Unmodified-Since", "Max-Forwards", "Proxy-Authorization", "Range",
    "Referer", "TE", "User-Agent",
    "Accept-Ranges", "Age", "ETag", "Location", "Proxy-Authenticate",
    "Retry-After", "Vary",
    "Allow", "Content-Encoding", "Content-Language", "Content-Length",
    "Content-Location", "Content-MD5", "Content-Range", "Content-Type",
    "X-SessionCookie", "X-Server-IP-Address"
  };

  pending_word_t pending_q[$];
  lookup_t       lookup_q[$];

  logic [hhnc_pkg::NUM_KEYWORDS-1:0] alive_keywords = {hhnc_pkg::NUM_KEYWORDS{1'b1}};
  int unsigned                       token_pos = 0;

  int  err_count = 0;
  int  words_sent = 0;
  int  total_words = 0;
  logic hold_off = 1'b0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ascii letters to lower case
  function automatic logic [7:0] lower_ascii(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // dictionary lookup for one accepted word
  task automatic match_word(input hhnc_pkg::hhnc_word_t w);
    lookup_t hit;
    bit      keep;
    hit = '0;
    if (w.empty_token) begin
      lookup_q.push_back(hit);
      alive_keywords = {hhnc_pkg::NUM_KEYWORDS{1'b1}};
      token_pos = 0;
      return;
    end
    for (int k = 0; k < hhnc_pkg::NUM_KEYWORDS; k++) begin
      keep = 1'b0;
      if (alive_keywords[k] && token_pos < hhnc_pkg::MAX_KEYWORD_LEN &&
          token_pos < header_names[k].len()) begin
        keep = lower_ascii(w.text_char) == lower_ascii(header_names[k][token_pos]);
      end
      if (!keep) begin
        alive_keywords[k] = 1'b0;
      end
    end
    if (token_pos < hhnc_pkg::MAX_KEYWORD_LEN) begin
      token_pos++;
    end
    if (!w.last_char) begin
      return;
    end
    // walk downwards so the lowest surviving index wins
    for (int k = hhnc_pkg::NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (alive_keywords[k] && header_names[k].len() == token_pos) begin
        hit.header_index = k[hhnc_pkg::INDEX_W-1:0];
        hit.found = 1'b1;
      end
    end
    lookup_q.push_back(hit);
    alive_keywords = {hhnc_pkg::NUM_KEYWORDS{1'b1}};
    token_pos = 0;
  endtask

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // idling phase follows progress through the stimulus
  function automatic int idle_phase();
    if (words_sent * 3 < total_words) begin
      return 0;
    end
    if (words_sent * 3 < 2 * total_words) begin
      return 1;
    end
    return 2;
  endfunction

  function automatic bit sender_idles();
    case (idle_phase())
      0: return $urandom_range(99) < 7;
      1: return $urandom_range(99) < 79;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    case (idle_phase())
      0: return $urandom_range(99) < 79;
      1: return $urandom_range(99) < 7;
      default: return 1'b0;
    endcase
  endfunction

  // name bytes, letters in random case when asked
  function automatic token_t name_bytes(input string s, input bit mix);
    token_t t;
    byte unsigned c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && lower_ascii(c) >= 8'h61 && lower_ascii(c) <= 8'h7A) begin
        c = $urandom_range(1) ? (lower_ascii(c) - 8'h20) : lower_ascii(c);
      end
      t.push_back(c);
    end
    return t;
  endfunction

  function automatic token_t random_bytes(input int n);
    token_t t;
    for (int i = 0; i < n; i++) begin
      t.push_back(byte'($urandom_range(255)));
    end
    return t;
  endfunction

  // queue token bytes; close marks the final byte
  task automatic push_token(input token_t t, input bit close, input bit drain_first);
    pending_word_t p;
    for (int i = 0; i < t.size(); i++) begin
      p.word.text_char = t[i];
      p.word.last_char = close && (i == t.size() - 1);
      p.word.empty_token = 1'b0;
      p.drain_first = drain_first && (i == 0);
      pending_q.push_back(p);
    end
  endtask

  task automatic push_empty(input bit last_flag, input bit drain_first);
    pending_word_t p;
    p.word.text_char = byte'($urandom_range(255));
    p.word.last_char = last_flag;
    p.word.empty_token = 1'b1;
    p.drain_first = drain_first;
    pending_q.push_back(p);
  endtask

  // stimulus and end of run
  initial begin
    token_t t;
    int     kind;
    int     k;
    int     n;
    int     directed_words;
    int     tokens_made;
    bit     drain;

    in_if.valid = 1'b0;
    in_if.text_char = '0;
    in_if.last_char = 1'b0;
    in_if.empty_token = 1'b0;
    out_if.ready = 1'b0;

    // directed tokens: case folding, empty tokens, byte extremes, prefixes
    push_token(name_bytes("tE", 1'b0), 1'b1, 1'b0);
    push_empty(1'b1, 1'b0);
    push_empty(1'b0, 1'b0);
    t = {8'h00};
    push_token(t, 1'b1, 1'b0);
    t = {8'hFF};
    push_token(t, 1'b1, 1'b0);
    push_token(name_bytes("VIA", 1'b0), 1'b1, 1'b0);
    push_token(name_bytes("Con", 1'b0), 1'b0, 1'b0);
    push_empty(1'b1, 1'b0);
    push_token(name_bytes("Vi", 1'b0), 1'b1, 1'b0);
    push_token(name_bytes("aGe", 1'b0), 1'b1, 1'b0);
    t = {8'h5A};
    push_token(t, 1'b1, 1'b0);
    t = {8'h41, 8'h40};
    push_token(t, 1'b1, 1'b0);
    directed_words = pending_q.size();

    // random tokens, mostly well-formed names in random case
    tokens_made = 0;
    while (pending_q.size() < directed_words + RANDOM_WORDS) begin
      kind = $urandom_range(99);
      k = $urandom_range(hhnc_pkg::NUM_KEYWORDS - 1);
      t = name_bytes(header_names[k], 1'b1);
      tokens_made++;
      drain = (tokens_made == 20) || (tokens_made == 70);
      if (kind < 55) begin
        push_token(t, 1'b1, drain);
      end else if (kind < 65) begin
        // one byte corrupted
        t[$urandom_range(t.size() - 1)] = byte'($urandom_range(255));
        push_token(t, 1'b1, drain);
      end else if (kind < 72) begin
        // cut short
        n = $urandom_range(t.size() - 1, 1);
        while (t.size() > n) void'(t.pop_back());
        push_token(t, 1'b1, drain);
      end else if (kind < 79) begin
        // trailing junk
        t = {t, random_bytes($urandom_range(3, 1))};
        push_token(t, 1'b1, drain);
      end else if (kind < 87) begin
        push_token(random_bytes($urandom_range(8, 1)), 1'b1, drain);
      end else if (kind < 92) begin
        // past the longest name
        t = name_bytes(header_names[hhnc_pkg::NUM_KEYWORDS - 1], 1'b1);
        t = {t, random_bytes($urandom_range(6, 1))};
        push_token(t, 1'b1, drain);
      end else if (kind < 96) begin
        push_empty($urandom_range(1), drain);
      end else begin
        // abandoned partway through by an empty token
        n = (t.size() > 1) ? $urandom_range(t.size() - 1, 1) : 1;
        while (t.size() > n) void'(t.pop_back());
        push_token(t, 1'b0, drain);
        push_empty($urandom_range(1), 1'b0);
      end
    end
    total_words = pending_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain everything, then allow for the pipeline latency
    while (pending_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (err_count == 0) begin
      $display("http_header_name_classifier_core verification clean");
    end else begin
      $display("http_header_name_classifier_core verification failed");
    end
    $finish;
  end

  // long receiver hold-off while the sender keeps streaming
  initial begin
    @(posedge rst_ni);
    while (words_sent * 3 < 2 * total_words + 60) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // token word driver
  always @(posedge clk_i or negedge rst_ni) begin
    pending_word_t p;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        match_word('{text_char: in_if.text_char, last_char: in_if.last_char,
                     empty_token: in_if.empty_token});
        words_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_q.size() != 0 && !sender_idles() &&
            !(pending_q[0].drain_first && lookup_q.size() != 0)) begin
          p = pending_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.text_char <= p.word.text_char;
          in_if.last_char <= p.word.last_char;
          in_if.empty_token <= p.word.empty_token;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // lookup result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (lookup_q.size() == 0) begin
          note_failure($sformatf("unexpected result word: found=%0d index=%0d",
                                 out_if.found, out_if.header_index));
        end else begin
          want = lookup_q.pop_front();
          if (out_if.found !== want.found || out_if.header_index !== want.header_index) begin
            note_failure($sformatf(
              "lookup mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
              want.found, want.header_index, out_if.found, out_if.header_index));
          end
        end
      end
      out_if.ready <= !hold_off && !receiver_idles();
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("http_header_name_classifier_core verification failed");
    $finish;
  end

endmodule
